[hw/rtl/spq_pkg.sv]
package spq_pkg;

	localparam int ID_BITS = 5;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_OUT_BITS = 6;

	typedef enum logic [1:0] {
		CMD_INSERT       = 2'd0,
		CMD_REMOVE_HEAD  = 2'd1,
		CMD_REMOVE_ENTRY = 2'd2,
		CMD_PEEK         = 2'd3
	} cmd_t;

	localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

	// Broadcast from the queue controller to every cell
	typedef struct packed {
		logic               en;
		logic               insert;
		logic               remove_head;
		logic               remove_entry;
		logic [ID_BITS-1:0] id;
	} cell_ctl_t;

endpackage

[hw/rtl/spq_cell.sv]
module spq_cell #(
	parameter int PRIO_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  spq_pkg::cell_ctl_t         ctl,
	input  logic [PRIO_BITS-1:0]       prio_new,
	input  logic                       prev_valid,
	input  logic [spq_pkg::ID_BITS-1:0] prev_id,
	input  logic [PRIO_BITS-1:0]       prev_prio,
	input  logic                       prev_go,
	input  logic                       prev_found,
	input  logic                       next_valid,
	input  logic [spq_pkg::ID_BITS-1:0] next_id,
	input  logic [PRIO_BITS-1:0]       next_prio,
	output logic                       valid,
	output logic [spq_pkg::ID_BITS-1:0] id,
	output logic [PRIO_BITS-1:0]       prio,
	output logic                       go,
	output logic                       found
);

	logic                        valid_q;
	logic [spq_pkg::ID_BITS-1:0] id_q;
	logic [PRIO_BITS-1:0]        prio_q;
	logic                        take_prev;
	logic                        take_new;
	logic                        take_next;

	// New item belongs here or nearer the head; monotone along the chain
	assign go = !valid_q || (prio_new > prio_q);
	assign found = prev_found || (valid_q && (id_q == ctl.id));

	assign take_prev = ctl.insert && prev_go;
	assign take_new  = ctl.insert && go && !prev_go;
	assign take_next = ctl.remove_head || (ctl.remove_entry && found);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.en) begin
			if (take_prev) begin
				valid_q <= prev_valid;
			end else if (take_new) begin
				valid_q <= 1'b1;
			end else if (take_next) begin
				valid_q <= next_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (take_prev) begin
				id_q   <= prev_id;
				prio_q <= prev_prio;
			end else if (take_new) begin
				id_q   <= ctl.id;
				prio_q <= prio_new;
			end else if (take_next) begin
				id_q   <= next_id;
				prio_q <= next_prio;
			end
		end
	end

	assign valid = valid_q;
	assign id    = id_q;
	assign prio  = prio_q;

endmodule

[hw/rtl/sorted_priority_queue.sv]
// Sorted priority queue of entry ids, highest priority at the head.
// Input channel (in_valid/in_stall): command, entry_id, priority_req. Commands
// insert, remove head, remove a given id, or peek at the head.
// Output channel (out_valid/out_stall): one item per input item with
// result_id, status, queue_empty and queue_count after the operation.
// The result is registered at the edge that accepts the command. Throughput is
// one item per cycle while no result waits under out_stall; every cell
// compares against the broadcast command and shifts with its neighbor in that
// same cycle, so the rate is set by the update of the cell row.
// While a result waits under out_stall, in_stall is raised and new items are
// held off; the result and the queue contents hold until it is taken.
// Equal priorities keep arrival order. Inserts into a full queue return the
// full status; misses and empty-queue reads return the empty status.
// Reset clears every cell's valid bit, the count and the output valid flag; the
// queue is empty and ready in the first cycle after reset.
module sorted_priority_queue #(
	parameter int DEPTH = 32,
	parameter int PRIO_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [4:0]  entry_id,
	input  logic [7:0]  priority_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  result_id,
	output logic [1:0]  status,
	output logic        queue_empty,
	output logic [5:0]  queue_count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IDW = spq_pkg::ID_BITS;

	logic                 accept;
	logic [PRIO_BITS-1:0] prio_new;
	spq_pkg::cell_ctl_t   ctl;

	logic                 c_valid [DEPTH];
	logic [IDW-1:0]       c_id    [DEPTH];
	logic [PRIO_BITS-1:0] c_prio  [DEPTH];
	logic                 c_go    [DEPTH];
	logic                 c_found [DEPTH];

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_next;
	logic [CW+5:0]        count_wide;
	logic [IDW-1:0]       res_id;
	logic [spq_pkg::STATUS_BITS-1:0] res_status;

	logic                 out_valid_q;
	logic [IDW-1:0]       result_id_q;
	logic [spq_pkg::STATUS_BITS-1:0] status_q;
	logic                 queue_empty_q;
	logic [5:0]           queue_count_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	generate
		if (PRIO_BITS > 8) begin : g_prio_ext
			assign prio_new = {{(PRIO_BITS-8){1'b0}}, priority_req};
		end else begin : g_prio_cut
			assign prio_new = priority_req[PRIO_BITS-1:0];
		end
	endgenerate

	always_comb begin
		ctl        = '0;
		ctl.en     = accept;
		ctl.id     = entry_id;
		res_id     = '0;
		res_status = spq_pkg::STATUS_DONE;
		count_next = count_q;
		unique case (spq_pkg::cmd_t'(command))
			spq_pkg::CMD_INSERT: begin
				if (c_valid[DEPTH-1]) begin
					res_status = spq_pkg::STATUS_FULL;
				end else begin
					ctl.insert = 1'b1;
					res_id     = entry_id;
					count_next = count_q + CW'(1);
				end
			end
			spq_pkg::CMD_REMOVE_HEAD: begin
				if (!c_valid[0]) begin
					res_status = spq_pkg::STATUS_EMPTY;
				end else begin
					ctl.remove_head = 1'b1;
					res_id          = c_id[0];
					count_next      = count_q - CW'(1);
				end
			end
			spq_pkg::CMD_REMOVE_ENTRY: begin
				// Cells drop only where the match chain is set; a miss changes nothing
				ctl.remove_entry = 1'b1;
				if (c_found[DEPTH-1]) begin
					res_id     = entry_id;
					count_next = count_q - CW'(1);
				end else begin
					res_status = spq_pkg::STATUS_EMPTY;
				end
			end
			spq_pkg::CMD_PEEK: begin
				if (!c_valid[0]) begin
					res_status = spq_pkg::STATUS_EMPTY;
				end else begin
					res_id = c_id[0];
				end
			end
			default: begin
				res_status = spq_pkg::STATUS_DONE;
			end
		endcase
	end

	assign count_wide = {6'd0, count_next};

	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			logic                 pv;
			logic [IDW-1:0]       pid;
			logic [PRIO_BITS-1:0] pprio;
			logic                 pgo;
			logic                 pfound;
			logic                 nv;
			logic [IDW-1:0]       nid;
			logic [PRIO_BITS-1:0] nprio;

			if (i == 0) begin : g_head
				assign pv     = 1'b0;
				assign pid    = '0;
				assign pprio  = '0;
				assign pgo    = 1'b0;
				assign pfound = 1'b0;
			end else begin : g_body
				assign pv     = c_valid[i-1];
				assign pid    = c_id[i-1];
				assign pprio  = c_prio[i-1];
				assign pgo    = c_go[i-1];
				assign pfound = c_found[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign nv    = 1'b0;
				assign nid   = '0;
				assign nprio = '0;
			end else begin : g_mid
				assign nv    = c_valid[i+1];
				assign nid   = c_id[i+1];
				assign nprio = c_prio[i+1];
			end

			spq_cell #(
				.PRIO_BITS(PRIO_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.prio_new  (prio_new),
				.prev_valid(pv),
				.prev_id   (pid),
				.prev_prio (pprio),
				.prev_go   (pgo),
				.prev_found(pfound),
				.next_valid(nv),
				.next_id   (nid),
				.next_prio (nprio),
				.valid     (c_valid[i]),
				.id        (c_id[i]),
				.prio      (c_prio[i]),
				.go        (c_go[i]),
				.found     (c_found[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_id_q   <= res_id;
			status_q      <= res_status;
			queue_empty_q <= (count_next == '0);
			queue_count_q <= count_wide[5:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign result_id   = result_id_q;
	assign status      = status_q;
	assign queue_empty = queue_empty_q;
	assign queue_count = queue_count_q;

endmodule

[tb/testbench.sv]
module testbench;

	localparam int QUEUE_DEPTH = 32;
	localparam int HOLD_CYCLES = 300;
	localparam int SEGMENTS = 26;
	localparam int SEGMENT_LEN = 50;

	typedef struct packed {
		logic [4:0] id;
		logic [1:0] status;
		logic       empty;
		logic [5:0] count;
	} result_t;

	typedef struct {
		spq_pkg::cmd_t cmd;
		logic [4:0]    id;
		logic [7:0]    prio;
		bit            typed;
		result_t       res;
	} op_row_t;

	typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] command;
	logic [4:0] entry_id;
	logic [7:0] priority_req;
	logic       out_valid;
	logic       out_stall;
	logic [4:0] result_id;
	logic [1:0] status;
	logic       queue_empty;
	logic [5:0] queue_count;

	sorted_priority_queue #(
		.DEPTH(QUEUE_DEPTH),
		.PRIO_BITS(8)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.entry_id(entry_id),
		.priority_req(priority_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_id(result_id),
		.status(status),
		.queue_empty(queue_empty),
		.queue_count(queue_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the ready queue, head at index 0
	logic [4:0] ready_id [QUEUE_DEPTH];
	logic [7:0] ready_prio [QUEUE_DEPTH];
	int         ready_len = 0;

	result_t    pending_results[$];
	op_row_t    directed_ops[$];
	int         mismatches = 0;
	bit         no_gaps = 1'b0;
	bit         hold_req = 1'b0;

	function automatic void drop_ready(int pos);
		int i;
		for (i = pos; i < ready_len - 1; i++) begin
			ready_id[i] = ready_id[i + 1];
			ready_prio[i] = ready_prio[i + 1];
		end
		ready_len--;
	endfunction

	function automatic result_t queue_op(spq_pkg::cmd_t c, logic [4:0] id,
			logic [7:0] prio);
		result_t r;
		int pos;
		int i;
		r = '0;
		case (c)
			spq_pkg::CMD_INSERT: begin
				if (ready_len >= QUEUE_DEPTH) begin
					r.status = spq_pkg::STATUS_FULL;
				end else begin
					// go before the first entry of strictly lower priority
					pos = ready_len;
					for (i = 0; i < ready_len; i++)
						if (pos == ready_len && prio > ready_prio[i])
							pos = i;
					for (i = ready_len; i > pos; i--) begin
						ready_id[i] = ready_id[i - 1];
						ready_prio[i] = ready_prio[i - 1];
					end
					ready_id[pos] = id;
					ready_prio[pos] = prio;
					ready_len++;
					r.id = id;
				end
			end
			spq_pkg::CMD_REMOVE_HEAD, spq_pkg::CMD_PEEK: begin
				if (ready_len == 0) begin
					r.status = spq_pkg::STATUS_EMPTY;
				end else begin
					r.id = ready_id[0];
					if (c == spq_pkg::CMD_REMOVE_HEAD)
						drop_ready(0);
				end
			end
			default: begin
				pos = ready_len;
				for (i = 0; i < ready_len; i++)
					if (pos == ready_len && ready_id[i] == id)
						pos = i;
				if (pos == ready_len) begin
					r.status = spq_pkg::STATUS_EMPTY;
				end else begin
					r.id = id;
					drop_ready(pos);
				end
			end
		endcase
		r.empty = (ready_len == 0);
		r.count = ready_len[5:0];
		return r;
	endfunction

	function automatic op_row_t op_row(spq_pkg::cmd_t c, int id, int prio, bit typed,
			int rid, logic [1:0] st, int rcount);
		op_row_t o;
		o.cmd = c;
		o.id = id[4:0];
		o.prio = prio[7:0];
		o.typed = typed;
		o.res.id = rid[4:0];
		o.res.status = st;
		o.res.empty = (rcount == 0);
		o.res.count = rcount[5:0];
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 25);
	endfunction

	function automatic op_row_t random_op(mix_t mix);
		op_row_t o;
		int r;
		r = $urandom_range(0, 99);
		o = op_row(spq_pkg::CMD_INSERT, $urandom_range(0, 31), $urandom_range(0, 255),
			1'b0, 0, spq_pkg::STATUS_DONE, 0);
		case (mix)
			MIX_FILL:
				o.cmd = (r < 85) ? spq_pkg::CMD_INSERT :
					spq_pkg::cmd_t'($urandom_range(1, 3));
			MIX_DRAIN:
				o.cmd = (r < 40) ? spq_pkg::CMD_REMOVE_HEAD :
					(r < 75) ? spq_pkg::CMD_REMOVE_ENTRY :
					(r < 85) ? spq_pkg::CMD_PEEK : spq_pkg::CMD_INSERT;
			default:
				o.cmd = (r < 40) ? spq_pkg::CMD_INSERT :
					(r < 60) ? spq_pkg::CMD_REMOVE_HEAD :
					(r < 85) ? spq_pkg::CMD_REMOVE_ENTRY : spq_pkg::CMD_PEEK;
		endcase
		// crowd priorities onto extremes and a few values to force ties
		case ($urandom_range(0, 3))
			0: o.prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			1: o.prio = 8'($urandom_range(0, 3) * 64);
			default: ;
		endcase
		if (o.cmd == spq_pkg::CMD_REMOVE_ENTRY && ready_len > 0 &&
				$urandom_range(0, 3) != 0)
			o.id = ready_id[$urandom_range(0, ready_len - 1)];
		return o;
	endfunction

	task automatic send_op(input op_row_t op);
		int gap;
		result_t predicted;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		command <= op.cmd;
		entry_id <= op.id;
		priority_req <= op.prio;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = queue_op(op.cmd, op.id, op.prio);
		pending_results.push_back(op.typed ? op.res : predicted);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic void compare_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	result_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual id %0d status %0d",
					$time, result_id, status);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("result_id", want.id, result_id);
				compare_field("status", want.status, status);
				compare_field("queue_empty", want.empty, queue_empty);
				compare_field("queue_count", want.count, queue_count);
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	int stall_left;
	int stall_len;

	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (no_gaps) begin
				out_stall <= 1'b0;
			end else begin
				stall_len = pick_gap();
				out_stall <= (stall_len > 0);
				if (stall_len > 0)
					stall_left = stall_len - 1;
			end
		end
	end

	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	int seg;
	int k;
	mix_t mix;

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = spq_pkg::CMD_INSERT;
		entry_id = '0;
		priority_req = '0;

		directed_ops.push_back(op_row(spq_pkg::CMD_PEEK, 0, 0, 1, 0,
			spq_pkg::STATUS_EMPTY, 0));
		directed_ops.push_back(op_row(spq_pkg::CMD_REMOVE_HEAD, 0, 0, 1, 0,
			spq_pkg::STATUS_EMPTY, 0));
		directed_ops.push_back(op_row(spq_pkg::CMD_REMOVE_ENTRY, 7, 0, 1, 0,
			spq_pkg::STATUS_EMPTY, 0));
		directed_ops.push_back(op_row(spq_pkg::CMD_INSERT, 31, 255, 1, 31,
			spq_pkg::STATUS_DONE, 1));
		directed_ops.push_back(op_row(spq_pkg::CMD_INSERT, 0, 0, 1, 0,
			spq_pkg::STATUS_DONE, 2));
		directed_ops.push_back(op_row(spq_pkg::CMD_INSERT, 5, 255, 1, 5,
			spq_pkg::STATUS_DONE, 3));
		directed_ops.push_back(op_row(spq_pkg::CMD_INSERT, 10, 128, 1, 10,
			spq_pkg::STATUS_DONE, 4));
		directed_ops.push_back(op_row(spq_pkg::CMD_PEEK, 0, 0, 1, 31,
			spq_pkg::STATUS_DONE, 4));
		directed_ops.push_back(op_row(spq_pkg::CMD_REMOVE_ENTRY, 5, 0, 1, 5,
			spq_pkg::STATUS_DONE, 3));
		directed_ops.push_back(op_row(spq_pkg::CMD_REMOVE_ENTRY, 3, 0, 1, 0,
			spq_pkg::STATUS_EMPTY, 3));
		directed_ops.push_back(op_row(spq_pkg::CMD_REMOVE_HEAD, 0, 0, 1, 31,
			spq_pkg::STATUS_DONE, 2));
		// duplicate id ahead of the older one, then equal-priority ordering
		directed_ops.push_back(op_row(spq_pkg::CMD_INSERT, 0, 200, 0, 0,
			spq_pkg::STATUS_DONE, 0));
		directed_ops.push_back(op_row(spq_pkg::CMD_INSERT, 21, 128, 0, 0,
			spq_pkg::STATUS_DONE, 0));
		directed_ops.push_back(op_row(spq_pkg::CMD_INSERT, 17, 1, 0, 0,
			spq_pkg::STATUS_DONE, 0));
		directed_ops.push_back(op_row(spq_pkg::CMD_REMOVE_ENTRY, 0, 0, 0, 0,
			spq_pkg::STATUS_DONE, 0));
		directed_ops.push_back(op_row(spq_pkg::CMD_PEEK, 0, 0, 0, 0,
			spq_pkg::STATUS_DONE, 0));
		directed_ops.push_back(op_row(spq_pkg::CMD_REMOVE_HEAD, 0, 0, 0, 0,
			spq_pkg::STATUS_DONE, 0));
		directed_ops.push_back(op_row(spq_pkg::CMD_REMOVE_HEAD, 0, 0, 0, 0,
			spq_pkg::STATUS_DONE, 0));
		directed_ops.push_back(op_row(spq_pkg::CMD_REMOVE_HEAD, 0, 0, 0, 0,
			spq_pkg::STATUS_DONE, 0));
		directed_ops.push_back(op_row(spq_pkg::CMD_REMOVE_HEAD, 0, 0, 0, 0,
			spq_pkg::STATUS_DONE, 0));
		directed_ops.push_back(op_row(spq_pkg::CMD_REMOVE_HEAD, 0, 0, 1, 0,
			spq_pkg::STATUS_EMPTY, 0));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_ops[i])
			send_op(directed_ops[i]);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			mix = mix_t'(seg % 3);
			no_gaps = (seg % 5 == 2);
			// hold the output during a fill run so the block backs up
			if (seg == 4)
				hold_req = 1'b1;
			if (seg == 7 || seg == 15)
				drain_results();
			for (k = 0; k < SEGMENT_LEN; k++)
				send_op(random_op(mix));
		end
		no_gaps = 1'b0;

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
tb/testbench.sv
